[rtl/sign_weight_conv3x3_binarize_assert.svh]
// Assertion macros for the binary-weight 3x3 convolution block.
`ifndef SIGN_WEIGHT_CONV3X3_BINARIZE_ASSERT_SVH
`define SIGN_WEIGHT_CONV3X3_BINARIZE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define SWC_ASSERT_NOW(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("swc assertion failed");
// Next-cycle implication, disabled during reset.
`define SWC_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("swc assertion failed");
`else
`define SWC_ASSERT_NOW(lbl, clk, rst, pre, post)
`define SWC_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

[rtl/swc_pkg.sv]
// Shared types, field widths and command codes of the binary-weight convolution block.
`timescale 1ns / 1ps
package swc_pkg;

  localparam int CMD_W        = 2;
  localparam int CHAN_W       = 20;
  localparam int CHANNELS     = 3;
  localparam int PIXEL_W      = CHAN_W * CHANNELS;
  localparam int TAPS         = 9;
  localparam int TAP_W        = 4;
  localparam int WEIGHT_W     = TAPS * CHANNELS;
  localparam int ENTRY_W      = 6;
  localparam int FEATURE_W    = 64;
  localparam int POS_W        = 5;
  localparam int FRAME_SIZE_W = 6;

  // Adder tree widths: three terms, nine terms, twenty-seven terms plus bias
  localparam int PA_W  = 22;
  localparam int PB_W  = 24;
  localparam int SUM_W = 25;

  localparam logic [FRAME_SIZE_W-1:0] FRAME_SIZE_RESET = 6'd32;

  localparam logic [CMD_W-1:0] CMD_PIXEL  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WEIGHT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BIAS   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_FETCH,
    S_CALC,
    S_PUSH,
    S_FLUSH
  } state_t;

endpackage

[rtl/swc_item_if.sv]
// Input channel: pixel words and weight/bias load words.
`timescale 1ns / 1ps
interface swc_item_if;
  logic                                valid;
  logic                                ready;
  logic [swc_pkg::CMD_W-1:0]           cmd;
  logic [swc_pkg::PIXEL_W-1:0]         pixel_word;
  logic [swc_pkg::ENTRY_W-1:0]         entry_index;
  logic [swc_pkg::WEIGHT_W-1:0]        weight_bits;
  logic signed [swc_pkg::CHAN_W-1:0]   bias_value;

  modport source (
    output valid, cmd, pixel_word, entry_index, weight_bits, bias_value,
    input  ready
  );
  modport sink (
    input  valid, cmd, pixel_word, entry_index, weight_bits, bias_value,
    output ready
  );
endinterface

[rtl/swc_result_if.sv]
// Output channel: one packed feature word per image position.
`timescale 1ns / 1ps
interface swc_result_if;
  logic                            valid;
  logic                            ready;
  logic [swc_pkg::FEATURE_W-1:0]   feature_bits;
  logic [swc_pkg::POS_W-1:0]       out_row;
  logic [swc_pkg::POS_W-1:0]       out_col;
  logic                            run_last;
  logic                            frame_last;

  modport source (
    output valid, feature_bits, out_row, out_col, run_last, frame_last,
    input  ready
  );
  modport sink (
    input  valid, feature_bits, out_row, out_col, run_last, frame_last,
    output ready
  );
endinterface

[rtl/sign_weight_conv3x3_binarize.sv]
// Top level of the binary-weight 3x3 convolution with zero border and sign threshold.
`timescale 1ns / 1ps
`include "sign_weight_conv3x3_binarize_assert.svh"
// Pixels enter in raster order; the block walks the zero-bordered grid itself and
// emits one packed feature word per image position, bit f set when the signed
// 27-term sum of feature f plus its bias is zero or more. Load words (cmd 1, 2)
// fill the weight and bias memories. A pixel word is walked through the grid steps
// it causes, and for each result the nine window taps come one per cycle through
// the single read port of the window memory, then one feature per cycle streams
// through the weight and bias memories into a three-stage adder tree. The flush
// state hands the last word of the pixel to the output. One word is taken at a
// time. frame_size takes effect at once and restarts the frame at position zero;
// the window memory needs no clearing because every tap is rewritten before it
// is read.
module sign_weight_conv3x3_binarize #(
  parameter int MAX_FRAME    = 32,
  parameter int OUT_FEATURES = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [swc_pkg::FRAME_SIZE_W-1:0]      cfg_wr_data,
  swc_item_if.sink                              items,
  swc_result_if.source                          results
);

  localparam int WIN_LEN = 2 * (MAX_FRAME + 2) + 3;
  localparam int AW      = $clog2(WIN_LEN);
  localparam int CW      = $clog2(MAX_FRAME + 3);
  localparam int EW      = $clog2(MAX_FRAME + 1);
  localparam int FW      = (OUT_FEATURES > 1) ? $clog2(OUT_FEATURES) : 1;
  localparam logic [FW:0] OF_N = (FW + 1)'(OUT_FEATURES);

  // ---------------------------------------------------------------- control
  swc_pkg::state_t state, state_next;

  logic item_acc, idx_ok, wt_we, bs_we, px_acc;
  logic step_en, fetch_issue, calc_issue, push_en, out_load, out_free;
  logic item_more;

  // frame walk
  logic [swc_pkg::FRAME_SIZE_W-1:0] frame_size;
  logic [CW-1:0] pad_col, pad_row, phase;
  logic [EW-1:0] emit_row, emit_col;
  logic [CW-1:0] s_eff, w_eff;
  logic [CW:0]   w2, phase_inc;
  logic [CW-1:0] phase_next, pad_col_next, pad_row_next, pcol_inc, prow_inc, ecol_inc;
  logic [EW-1:0] emit_row_next, emit_col_next;
  logic          is_border, din_is_pix, last_px, phase_act, emit, restart;

  // current pixel word
  logic [swc_pkg::PIXEL_W-1:0] pix;
  logic                        pix_done, tail;

  // window memory
  logic [swc_pkg::PIXEL_W-1:0] win_mem [WIN_LEN];
  logic [AW-1:0]               head, head_next, back, rd_addr;
  logic [AW:0]                 diff;
  logic [CW:0]                 row_term;
  logic [1:0]                  col_term;
  logic [swc_pkg::TAP_W-1:0]   fcnt, rd_tap;
  logic                        rd_vld;
  logic [swc_pkg::PIXEL_W-1:0] rd_data;
  logic [swc_pkg::PIXEL_W-1:0] win_reg [swc_pkg::TAPS];

  // weight and bias memories, feature pipeline
  logic [swc_pkg::WEIGHT_W-1:0]      wt_mem [OUT_FEATURES];
  logic signed [swc_pkg::CHAN_W-1:0] bs_mem [OUT_FEATURES];
  logic [swc_pkg::WEIGHT_W-1:0]      wt_q;
  logic signed [swc_pkg::CHAN_W-1:0] bs_q, bs_a, bs_b;
  logic [FW:0]                       ccnt;
  logic                              mv1, mv2, mv3, ml1, ml2, ml3;
  logic signed [swc_pkg::CHAN_W-1:0] chan;
  logic signed [swc_pkg::PA_W-1:0]   pa_next [swc_pkg::TAPS];
  logic signed [swc_pkg::PA_W-1:0]   pa [swc_pkg::TAPS];
  logic signed [swc_pkg::PB_W-1:0]   pb_next [3];
  logic signed [swc_pkg::PB_W-1:0]   pb [3];
  logic signed [swc_pkg::SUM_W-1:0]  sum_c;
  logic                              feat_bit;
  logic [OUT_FEATURES-1:0]           feat_acc;

  // result hold and output register
  logic [swc_pkg::POS_W-1:0] cur_row, cur_col;
  logic                      cur_flast;
  logic [OUT_FEATURES-1:0]   pend_feat;
  logic [swc_pkg::POS_W-1:0] pend_row, pend_col;
  logic                      pend_flast, pend_valid;
  logic [swc_pkg::FEATURE_W-1:0] out_feat;
  logic [swc_pkg::POS_W-1:0] out_row, out_col;
  logic                      out_rlast, out_flast, out_valid;

  assign item_acc = items.valid && items.ready;
  assign idx_ok   = {1'b0, items.entry_index} < (swc_pkg::ENTRY_W + 1)'(OUT_FEATURES);
  assign wt_we    = item_acc && (items.cmd == swc_pkg::CMD_WEIGHT) && idx_ok;
  assign bs_we    = item_acc && (items.cmd == swc_pkg::CMD_BIAS) && idx_ok;
  assign px_acc   = item_acc && (items.cmd == swc_pkg::CMD_PIXEL);
  assign out_free = !out_valid || results.ready;
  assign item_more = !pix_done || (tail && !(pad_row == '0 && pad_col == '0));

  // ---------------------------------------------------------------- FSM
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      swc_pkg::S_IDLE: begin
        if (px_acc) state_next = swc_pkg::S_STEP;
      end
      swc_pkg::S_STEP: begin
        if (!item_more) state_next = swc_pkg::S_FLUSH;
        else if (emit) state_next = swc_pkg::S_FETCH;
      end
      swc_pkg::S_FETCH: begin
        if (fcnt == swc_pkg::TAP_W'(swc_pkg::TAPS)) state_next = swc_pkg::S_CALC;
      end
      swc_pkg::S_CALC: begin
        if (ml3) state_next = swc_pkg::S_PUSH;
      end
      swc_pkg::S_PUSH: begin
        if (!pend_valid || out_free) state_next = swc_pkg::S_STEP;
      end
      swc_pkg::S_FLUSH: begin
        if (!pend_valid || out_free) state_next = swc_pkg::S_IDLE;
      end
      default: state_next = swc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    items.ready = 1'b0;
    step_en     = 1'b0;
    fetch_issue = 1'b0;
    calc_issue  = 1'b0;
    push_en     = 1'b0;
    out_load    = 1'b0;
    case (state)
      swc_pkg::S_IDLE:  items.ready = 1'b1;
      swc_pkg::S_STEP:  step_en = item_more;
      swc_pkg::S_FETCH: fetch_issue = fcnt < swc_pkg::TAP_W'(swc_pkg::TAPS);
      swc_pkg::S_CALC:  calc_issue = ccnt < OF_N;
      swc_pkg::S_PUSH: begin
        push_en  = !pend_valid || out_free;
        out_load = pend_valid && out_free;
      end
      swc_pkg::S_FLUSH: out_load = pend_valid && out_free;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- grid walk
  always_comb begin
    if (frame_size == '0) begin
      s_eff = CW'(1);
    end else if (frame_size > swc_pkg::FRAME_SIZE_W'(MAX_FRAME)) begin
      s_eff = CW'(MAX_FRAME);
    end else begin
      s_eff = CW'(frame_size);
    end
    w_eff = s_eff + CW'(2);
    w2    = {w_eff, 1'b0};

    is_border  = (pad_row == '0) || (pad_row > s_eff) || (pad_col == '0) || (pad_col > s_eff);
    din_is_pix = !pix_done && !is_border;
    last_px    = (pad_row == s_eff) && (pad_col == s_eff);

    phase_act = (phase != '0) || (pad_row > CW'(2)) ||
                ((pad_row == CW'(2)) && (pad_col >= CW'(2)));
    phase_inc = {1'b0, phase} + (CW + 1)'(1);
    if (!phase_act) begin
      phase_next = phase;
    end else if (phase_inc > {1'b0, w_eff}) begin
      phase_next = CW'(1);
    end else begin
      phase_next = phase_inc[CW-1:0];
    end
    emit = (phase_next != '0) && (phase_next <= s_eff);

    ecol_inc      = CW'(emit_col) + CW'(1);
    emit_col_next = emit_col;
    emit_row_next = emit_row;
    if (emit) begin
      if (ecol_inc >= s_eff) begin
        emit_col_next = '0;
        emit_row_next = emit_row + EW'(1);
      end else begin
        emit_col_next = EW'(ecol_inc);
      end
    end

    pcol_inc     = pad_col + CW'(1);
    prow_inc     = pad_row + CW'(1);
    restart      = 1'b0;
    pad_col_next = pcol_inc;
    pad_row_next = pad_row;
    if (pcol_inc >= w_eff) begin
      pad_col_next = '0;
      if (prow_inc >= w_eff) begin
        pad_row_next = '0;
        restart      = 1'b1;
      end else begin
        pad_row_next = prow_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_size <= swc_pkg::FRAME_SIZE_RESET;
      pad_col    <= '0;
      pad_row    <= '0;
      phase      <= '0;
      emit_row   <= '0;
      emit_col   <= '0;
    end else if (cfg_wr_en) begin
      frame_size <= cfg_wr_data;
      pad_col    <= '0;
      pad_row    <= '0;
      phase      <= '0;
      emit_row   <= '0;
      emit_col   <= '0;
    end else if (step_en) begin
      pad_col <= pad_col_next;
      pad_row <= pad_row_next;
      if (restart) begin
        phase    <= '0;
        emit_row <= '0;
        emit_col <= '0;
      end else begin
        phase    <= phase_next;
        emit_row <= emit_row_next;
        emit_col <= emit_col_next;
      end
    end
  end

  // position of the word the current step produces
  always_ff @(posedge clk) begin
    if (step_en && emit) begin
      cur_row   <= swc_pkg::POS_W'(emit_row);
      cur_col   <= swc_pkg::POS_W'(emit_col);
      cur_flast <= (CW'(emit_row) == s_eff - CW'(1)) && (CW'(emit_col) == s_eff - CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (px_acc) pix <= items.pixel_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_done <= 1'b1;
      tail     <= 1'b0;
    end else if (px_acc) begin
      pix_done <= 1'b0;
      tail     <= 1'b0;
    end else if (step_en && din_is_pix) begin
      pix_done <= 1'b1;
      tail     <= last_px;
    end
  end

  // ---------------------------------------------------------------- window memory
  assign head_next = (head == AW'(WIN_LEN - 1)) ? '0 : head + AW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else if (step_en) begin
      head <= head_next;
    end
  end

  // tap (ky, kx) sits (2-ky) padded lines and (2-kx) pixels behind the newest word
  always_comb begin
    if (fcnt inside {[4'd0:4'd2]}) row_term = w2;
    else if (fcnt inside {[4'd3:4'd5]}) row_term = {1'b0, w_eff};
    else row_term = '0;
    if (fcnt inside {4'd0, 4'd3, 4'd6}) col_term = 2'd2;
    else if (fcnt inside {4'd1, 4'd4, 4'd7}) col_term = 2'd1;
    else col_term = 2'd0;
    back    = AW'(row_term) + AW'(col_term);
    diff    = {1'b0, head} - {1'b0, back};
    rd_addr = diff[AW] ? AW'(diff + (AW + 1)'(WIN_LEN)) : diff[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (step_en) win_mem[head_next] <= din_is_pix ? pix : '0;
    if (fetch_issue) begin
      rd_data <= win_mem[rd_addr];
      rd_tap  <= fcnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fcnt   <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= fetch_issue;
      if (step_en) fcnt <= '0;
      else if (fetch_issue) fcnt <= fcnt + swc_pkg::TAP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld) win_reg[rd_tap] <= rd_data;
  end

  // ---------------------------------------------------------------- feature pipeline
  always_ff @(posedge clk) begin
    if (wt_we) wt_mem[items.entry_index[FW-1:0]] <= items.weight_bits;
    if (bs_we) bs_mem[items.entry_index[FW-1:0]] <= items.bias_value;
    if (calc_issue) begin
      wt_q <= wt_mem[ccnt[FW-1:0]];
      bs_q <= bs_mem[ccnt[FW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ccnt <= '0;
      mv1  <= 1'b0;
      mv2  <= 1'b0;
      mv3  <= 1'b0;
      ml1  <= 1'b0;
      ml2  <= 1'b0;
      ml3  <= 1'b0;
    end else begin
      if (state == swc_pkg::S_FETCH) ccnt <= '0;
      else if (calc_issue) ccnt <= ccnt + (FW + 1)'(1);
      mv1 <= calc_issue;
      ml1 <= calc_issue && (ccnt == OF_N - (FW + 1)'(1));
      mv2 <= mv1;
      ml2 <= ml1;
      mv3 <= mv2;
      ml3 <= ml2;
    end
  end

  // stage A: add or subtract the three channels of each tap
  always_comb begin
    chan = '0;
    for (int t = 0; t < swc_pkg::TAPS; t++) begin
      pa_next[t] = '0;
      for (int c = 0; c < swc_pkg::CHANNELS; c++) begin
        chan = signed'(win_reg[t][c*swc_pkg::CHAN_W +: swc_pkg::CHAN_W]);
        if (wt_q[t*swc_pkg::CHANNELS + c]) begin
          pa_next[t] = pa_next[t] + swc_pkg::PA_W'(chan);
        end else begin
          pa_next[t] = pa_next[t] - swc_pkg::PA_W'(chan);
        end
      end
    end
  end

  // stage B: one partial per kernel row
  always_comb begin
    for (int g = 0; g < 3; g++) begin
      pb_next[g] = swc_pkg::PB_W'(pa[g*3]) + swc_pkg::PB_W'(pa[g*3 + 1]) +
                   swc_pkg::PB_W'(pa[g*3 + 2]);
    end
  end

  // stage C: add bias, keep the sign
  assign sum_c = swc_pkg::SUM_W'(pb[0]) + swc_pkg::SUM_W'(pb[1]) +
                 swc_pkg::SUM_W'(pb[2]) + swc_pkg::SUM_W'(bs_b);
  assign feat_bit = ~sum_c[swc_pkg::SUM_W-1];

  always_ff @(posedge clk) begin
    if (mv1) begin
      pa   <= pa_next;
      bs_a <= bs_q;
    end
    if (mv2) begin
      pb   <= pb_next;
      bs_b <= bs_a;
    end
    // features arrive in order, so shift each bit in from the top
    if (mv3) feat_acc <= (feat_acc >> 1) | (OUT_FEATURES'(feat_bit) << (OUT_FEATURES - 1));
  end

  // ---------------------------------------------------------------- result hand-off
  // hold each word until it is known whether another word of the same pixel follows
  always_ff @(posedge clk) begin
    if (push_en) begin
      pend_feat  <= feat_acc;
      pend_row   <= cur_row;
      pend_col   <= cur_col;
      pend_flast <= cur_flast;
    end
    if (out_load) begin
      out_feat  <= swc_pkg::FEATURE_W'(pend_feat);
      out_row   <= pend_row;
      out_col   <= pend_col;
      out_flast <= pend_flast;
      out_rlast <= (state == swc_pkg::S_FLUSH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (push_en) pend_valid <= 1'b1;
      else if (out_load) pend_valid <= 1'b0;
      if (out_load) out_valid <= 1'b1;
      else if (results.ready) out_valid <= 1'b0;
    end
  end

  assign results.valid        = out_valid;
  assign results.feature_bits = out_feat;
  assign results.out_row      = out_row;
  assign results.out_col      = out_col;
  assign results.run_last     = out_rlast;
  assign results.frame_last   = out_flast;

  // ---------------------------------------------------------------- assertions
  `SWC_ASSERT_NOW(a_idle_no_pending, clk, rst, state == swc_pkg::S_IDLE, !pend_valid)
  `SWC_ASSERT_NOW(a_load_only_free, clk, rst, out_load, !out_valid || results.ready)
  `SWC_ASSERT_NOW(a_last_on_diag, clk, rst, out_valid && out_flast, out_row == out_col)
  `SWC_ASSERT_NEXT(a_pixel_starts_walk, clk, rst, px_acc, state == swc_pkg::S_STEP)

endmodule

[tb/sv/tb_sign_weight_conv3x3_binarize.sv]
// Self-checking testbench of the binary-weight 3x3 convolution: own window predictor, random traffic.
`timescale 1ns / 1ps
module tb_sign_weight_conv3x3_binarize;
  import swc_pkg::*;

  localparam int MAX_FRAME     = 32;
  localparam int OUT_FEATURES  = 64;
  localparam int WIN_LEN       = 2 * (MAX_FRAME + 2) + 3;
  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_ITEMS  = 200;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [FEATURE_W-1:0] bits;
    logic [POS_W-1:0]     row;
    logic [POS_W-1:0]     col;
    logic                 run_last;
    logic                 frame_last;
  } conv_word_t;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [PIXEL_W-1:0]       pixel;
    logic [ENTRY_W-1:0]       idx;
    logic [WEIGHT_W-1:0]      wbits;
    logic signed [CHAN_W-1:0] bias;
  } stream_item_t;

  logic                    clk;
  logic                    rst;
  logic                    cfg_wr_en;
  logic [FRAME_SIZE_W-1:0] cfg_wr_data;

  swc_item_if   items_ch ();
  swc_result_if results_ch ();

  sign_weight_conv3x3_binarize #(
    .MAX_FRAME    (MAX_FRAME),
    .OUT_FEATURES (OUT_FEATURES)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .items       (items_ch),
    .results     (results_ch)
  );

  // Predictor state
  logic [PIXEL_W-1:0]       win_px [WIN_LEN];
  logic [WEIGHT_W-1:0]      weight_mem [OUT_FEATURES];
  logic signed [CHAN_W-1:0] bias_mem [OUT_FEATURES];
  logic [FRAME_SIZE_W-1:0]  frame_size_q;
  int unsigned              pad_col, pad_row, win_phase, emit_row, emit_col;

  conv_word_t pending_words [$];
  conv_word_t item_words [$];
  int         mismatches;
  int         cycle_count;
  bit         quiet_stretch;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_sign_weight_conv3x3_binarize: done, errors");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one; none during a quiet stretch
  function automatic int pause_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_stretch || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned frame_side();
    if (frame_size_q == '0) return 1;
    if (frame_size_q > MAX_FRAME) return MAX_FRAME;
    return frame_size_q;
  endfunction

  function automatic void restart_frame();
    pad_col = 0; pad_row = 0; win_phase = 0; emit_row = 0; emit_col = 0;
  endfunction

  function automatic logic [FEATURE_W-1:0] threshold_features(int unsigned s);
    logic [FEATURE_W-1:0]     bits;
    logic [PIXEL_W-1:0]       px;
    logic signed [CHAN_W-1:0] ch;
    int                       acc;
    int unsigned              back, tap;
    bits = '0;
    for (int f = 0; f < OUT_FEATURES; f++) begin
      acc = 0;
      for (int ky = 0; ky < 3; ky++) begin
        for (int kx = 0; kx < 3; kx++) begin
          back = (2 - ky) * (s + 2) + (2 - kx);
          px   = win_px[WIN_LEN - 1 - back];
          tap  = ky * 3 + kx;
          for (int c = 0; c < CHANNELS; c++) begin
            ch = px[CHAN_W*c +: CHAN_W];
            if (weight_mem[f][tap*CHANNELS + c]) acc += ch;
            else acc -= ch;
          end
        end
      end
      acc += bias_mem[f];
      if (acc >= 0) bits[f] = 1'b1;
    end
    return bits;
  endfunction

  // One padded grid position: shift in, emit when the window is complete
  function automatic void step_grid(logic [PIXEL_W-1:0] din);
    int unsigned s, w;
    conv_word_t  word;
    s = frame_side();
    w = s + 2;
    for (int i = 0; i < WIN_LEN - 1; i++) win_px[i] = win_px[i+1];
    win_px[WIN_LEN-1] = din;
    if (win_phase > 0 || pad_row > 2 || (pad_row == 2 && pad_col >= 2)) begin
      win_phase++;
      if (win_phase > w) win_phase = 1;
    end
    if (win_phase >= 1 && win_phase <= s) begin
      word.bits       = threshold_features(s);
      word.row        = POS_W'(emit_row);
      word.col        = POS_W'(emit_col);
      word.run_last   = 1'b0;
      word.frame_last = (emit_row == s - 1 && emit_col == s - 1);
      item_words.push_back(word);
      emit_col++;
      if (emit_col >= s) begin
        emit_col = 0;
        emit_row++;
      end
    end
    pad_col++;
    if (pad_col >= w) begin
      pad_col = 0;
      pad_row++;
      if (pad_row >= w) restart_frame();
    end
  endfunction

  function automatic bit on_border(int unsigned s);
    return pad_row == 0 || pad_row > s || pad_col == 0 || pad_col > s;
  endfunction

  function automatic void predict_conv_item(stream_item_t it);
    int unsigned s;
    bit          last_px;
    item_words.delete();
    case (it.cmd)
      CMD_WEIGHT: weight_mem[it.idx] = it.wbits;
      CMD_BIAS:   bias_mem[it.idx] = it.bias;
      CMD_PIXEL: begin
        s = frame_side();
        while (on_border(s)) step_grid('0);
        last_px = (pad_row == s && pad_col == s);
        step_grid(it.pixel);
        // Walk the rest of the grid after the final pixel of the frame
        if (last_px) begin
          while (!(pad_row == 0 && pad_col == 0)) step_grid('0);
        end
      end
      default: ;
    endcase
    if (item_words.size() > 0) item_words[item_words.size()-1].run_last = 1'b1;
    foreach (item_words[i]) pending_words.push_back(item_words[i]);
  endfunction

  function automatic logic [PIXEL_W-1:0] random_pixel();
    logic [PIXEL_W-1:0] px;
    int                 r;
    for (int c = 0; c < CHANNELS; c++) begin
      r = $urandom_range(0, 9);
      case (r)
        0:       px[CHAN_W*c +: CHAN_W] = 20'h7FFFF;
        1:       px[CHAN_W*c +: CHAN_W] = 20'h80000;
        2:       px[CHAN_W*c +: CHAN_W] = 20'h00000;
        3:       px[CHAN_W*c +: CHAN_W] = 20'hFFFFF;
        default: px[CHAN_W*c +: CHAN_W] = CHAN_W'($urandom);
      endcase
    end
    return px;
  endfunction

  // Unused fields carry random bits so that every input bit toggles
  function automatic stream_item_t make_item(logic [CMD_W-1:0] cmd, logic [PIXEL_W-1:0] px,
                                             logic [ENTRY_W-1:0] idx,
                                             logic [WEIGHT_W-1:0] wbits,
                                             logic signed [CHAN_W-1:0] bias);
    stream_item_t it;
    it.cmd   = cmd;
    it.pixel = px;
    it.idx   = idx;
    it.wbits = wbits;
    it.bias  = bias;
    return it;
  endfunction

  function automatic stream_item_t pixel_item(logic [PIXEL_W-1:0] px);
    return make_item(CMD_PIXEL, px, ENTRY_W'($urandom), WEIGHT_W'($urandom),
                     CHAN_W'($urandom));
  endfunction

  function automatic logic [WEIGHT_W-1:0] random_weights();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '1;
    if (r == 1) return '0;
    return WEIGHT_W'($urandom);
  endfunction

  function automatic logic signed [CHAN_W-1:0] random_bias();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 20'sh7FFFF;
    if (r == 1) return 20'sh80000;
    if (r == 2) return '0;
    return CHAN_W'($urandom);
  endfunction

  function automatic stream_item_t random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 82) return pixel_item(random_pixel());
    if (r < 90)
      return make_item(CMD_WEIGHT, random_pixel(), ENTRY_W'($urandom), random_weights(),
                       CHAN_W'($urandom));
    if (r < 97)
      return make_item(CMD_BIAS, random_pixel(), ENTRY_W'($urandom), WEIGHT_W'($urandom),
                       random_bias());
    return make_item(CMD_UNUSED, random_pixel(), ENTRY_W'($urandom), WEIGHT_W'($urandom),
                     CHAN_W'($urandom));
  endfunction

  // Present one word, hold it until taken, predict, then idle for a random gap, possibly none
  task automatic send_item(stream_item_t it);
    int gap;
    items_ch.valid       <= 1'b1;
    items_ch.cmd         <= it.cmd;
    items_ch.pixel_word  <= it.pixel;
    items_ch.entry_index <= it.idx;
    items_ch.weight_bits <= it.wbits;
    items_ch.bias_value  <= it.bias;
    do @(posedge clk); while (!items_ch.ready);
    predict_conv_item(it);
    gap = pause_cycles();
    if (gap > 0) begin
      items_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle_idle();
    items_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame_size(logic [FRAME_SIZE_W-1:0] v);
    settle_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    frame_size_q = v;
    restart_frame();
  endtask

  task automatic send_pixels(int count);
    for (int i = 0; i < count; i++) send_item(pixel_item(random_pixel()));
  endtask

  // Fill every weight and bias entry; the first entries take the extremes
  task automatic load_tables();
    logic [WEIGHT_W-1:0]      w;
    logic signed [CHAN_W-1:0] b;
    for (int f = 0; f < OUT_FEATURES; f++) begin
      w = (f == 0) ? '1 : (f == 1) ? '0 : WEIGHT_W'($urandom);
      b = (f == 0) ? 20'sh80000 : (f == 1) ? 20'sh7FFFF : (f == 2) ? '0 : random_bias();
      send_item(make_item(CMD_WEIGHT, random_pixel(), ENTRY_W'(f), w, CHAN_W'($urandom)));
      send_item(make_item(CMD_BIAS, random_pixel(), ENTRY_W'(f), WEIGHT_W'($urandom), b));
    end
  endtask

  // Frame size left at its reset value: enough pixels to fill the window
  task automatic test_reset_frame_size();
    send_pixels(38);
  endtask

  task automatic test_frame_size_limits();
    write_frame_size(6'd0);
    send_pixels(3);
    write_frame_size(6'd1);
    send_pixels(2);
    write_frame_size(6'd63);
    send_pixels(37);
    write_frame_size(6'd2);
    send_pixels(4);
  endtask

  task automatic test_pixel_extremes();
    logic [PIXEL_W-1:0] px [9];
    px[0] = {3{20'h7FFFF}};
    px[1] = {3{20'h80000}};
    px[2] = '0;
    px[3] = '1;
    px[4] = {20'h7FFFF, 20'h80000, 20'h7FFFF};
    px[5] = {20'h80000, 20'h7FFFF, 20'h00001};
    px[6] = {3{20'h7FFFF}};
    px[7] = {3{20'h80000}};
    px[8] = {20'h00000, 20'hFFFFF, 20'h7FFFF};
    write_frame_size(6'd3);
    for (int i = 0; i < 9; i++) begin
      send_item(pixel_item(px[i]));
      // Loads and an ignored word in the middle of the frame
      if (i == 3) send_item(make_item(CMD_UNUSED, '1, '1, '1, '1));
      if (i == 5) send_item(make_item(CMD_WEIGHT, '0, 6'd63, '1, '0));
      if (i == 6) send_item(make_item(CMD_BIAS, '1, 6'd63, '0, 20'sh80000));
    end
  endtask

  task automatic test_random_traffic();
    int                      sent, span, phase_no;
    int                      r;
    stream_item_t            it;
    logic [FRAME_SIZE_W-1:0] size_v;
    sent     = 0;
    phase_no = 0;
    while (sent < RANDOM_ITEMS) begin
      r      = $urandom_range(0, 99);
      size_v = (r < 85) ? FRAME_SIZE_W'($urandom_range(0, 6))
                        : FRAME_SIZE_W'($urandom_range(7, 12));
      write_frame_size(size_v);
      quiet_stretch = (phase_no == 1);
      span = $urandom_range(12, 40);
      for (int k = 0; k < span; k++) begin
        it = random_item();
        send_item(it);
        if (it.cmd != CMD_UNUSED) sent++;
        // Hold off now and then until the block has caught up
        if ($urandom_range(0, 99) < 4) settle_idle();
      end
      quiet_stretch = 1'b0;
      phase_no++;
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_checker
    conv_word_t want;
    if (!rst && results_ch.valid && results_ch.ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, got bits %h row %0d col %0d",
                 $time, results_ch.feature_bits, results_ch.out_row, results_ch.out_col);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        check_field("feature_bits", want.bits, results_ch.feature_bits);
        check_field("out_row", want.row, results_ch.out_row);
        check_field("out_col", want.col, results_ch.out_col);
        check_field("run_last", want.run_last, results_ch.run_last);
        check_field("frame_last", want.frame_last, results_ch.frame_last);
      end
    end
  end

  // Receiver: bursts of ready broken by random stalls
  initial begin : result_stalls
    int burst, gap;
    results_ch.ready <= 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      burst = $urandom_range(1, 20);
      results_ch.ready <= 1'b1;
      repeat (burst) @(posedge clk);
      gap = pause_cycles();
      if (gap > 0) begin
        results_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    rst                  <= 1'b1;
    cfg_wr_en            <= 1'b0;
    cfg_wr_data          <= '0;
    items_ch.valid       <= 1'b0;
    items_ch.cmd         <= CMD_PIXEL;
    items_ch.pixel_word  <= '0;
    items_ch.entry_index <= '0;
    items_ch.weight_bits <= '0;
    items_ch.bias_value  <= '0;
    mismatches    = 0;
    cycle_count   = 0;
    quiet_stretch = 1'b0;
    for (int i = 0; i < WIN_LEN; i++) win_px[i] = '0;
    for (int f = 0; f < OUT_FEATURES; f++) begin
      weight_mem[f] = '0;
      bias_mem[f]   = '0;
    end
    frame_size_q = FRAME_SIZE_RESET;
    restart_frame();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    load_tables();
    test_reset_frame_size();
    test_frame_size_limits();
    test_pixel_extremes();
    test_random_traffic();
    settle_idle();
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("tb_sign_weight_conv3x3_binarize: done, clean");
    end else begin
      $display("tb_sign_weight_conv3x3_binarize: done, errors");
    end
    $finish;
  end

endmodule
